### hw/rtl/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared types, codes and helpers for the vertex skinning core.
// ----------------------------------------------------------------------------
package lbvs_pkg;

    localparam int ELEMS = 12;
    localparam int INFL  = 4;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [7:0] CFG_JOINT_COUNT = 8'd0;
    localparam logic [7:0] CFG_IDENTITY    = 8'd1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  slot;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] joints;
        logic [63:0] weights;
    } t_item;

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sh0_0000_0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -72'sh0_0000_0000_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

### hw/rtl/lbvs_fifo.sv
// ----------------------------------------------------------------------------
// lbvs_fifo
// Small register queue with level output.
// ----------------------------------------------------------------------------
module lbvs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_rdata,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH):0]     o_level
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_level = r_cnt;
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end
endmodule

### hw/rtl/lbvs_front.sv
// ----------------------------------------------------------------------------
// lbvs_front
// Accepts items, drops loads outside the table, queues the rest.
// ----------------------------------------------------------------------------
module lbvs_front #(
    parameter int MAX_JOINTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  lbvs_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output lbvs_pkg::t_item o_item
);
    import lbvs_pkg::*;

    logic  keep;
    logic  q_empty;
    t_item q_data;
    logic [$clog2(4):0] q_level;

    always_comb begin
        keep = 1'b1;
        if (i_item.kind == KIND_LOAD) begin
            keep = (9'(i_item.slot) < 9'(MAX_JOINTS)) && (i_item.elem < 4'(ELEMS));
        end
    end

    lbvs_fifo #(.WIDTH($bits(t_item)), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_wdata (i_item),
        .i_pop   (i_pop),
        .o_rdata (q_data),
        .o_empty (q_empty),
        .o_full  (o_full),
        .o_level (q_level)
    );

    assign o_valid = !q_empty && (q_level != '0);
    assign o_item  = q_data;
endmodule

### hw/rtl/lbvs_back.sv
// ----------------------------------------------------------------------------
// lbvs_back
// Joint table banks and the blend/transform pipeline.
// ----------------------------------------------------------------------------
module lbvs_back #(
    parameter int MAX_JOINTS = 64,
    parameter int OUT_DEPTH  = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  lbvs_pkg::t_item            i_item,
    output logic                       o_pop,
    input  logic [6:0]                 i_joint_count,
    input  logic                       i_identity,
    input  logic [$clog2(OUT_DEPTH):0] i_out_level,
    output logic                       o_res_valid,
    output logic [31:0]                o_res_x,
    output logic [31:0]                o_res_y,
    output logic [31:0]                o_res_z
);
    import lbvs_pkg::*;

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int LW = $clog2(OUT_DEPTH) + 1;

    logic [8:0]  limit;
    logic [2:0]  inflight;
    logic        is_vtx, do_load;
    logic [31:0] pos_in [3];

    logic        r_v1, r_v2, r_v3, r_v4, r_v5;
    logic        r_id1, r_id2, r_id3, r_id4, r_id5;
    logic [31:0] r_pos1 [3];
    logic [31:0] r_pos2 [3];
    logic [31:0] r_pos3 [3];
    logic [31:0] r_pos4 [3];
    logic [31:0] r_pos5 [3];
    logic [15:0] r_w1 [INFL];
    logic        r_ok1 [INFL];
    logic [31:0] r_row [INFL][ELEMS];

    logic signed [48:0] n_p2 [ELEMS][INFL];
    logic signed [48:0] r_p2 [ELEMS][INFL];
    logic signed [31:0] n_b3 [ELEMS];
    logic signed [31:0] r_b3 [ELEMS];
    logic signed [63:0] n_q4 [3][3];
    logic signed [63:0] r_q4 [3][3];
    logic signed [31:0] r_t4 [3];
    logic signed [66:0] n_s5 [3];
    logic signed [66:0] r_s5 [3];

    assign limit    = (9'(i_joint_count) > 9'(MAX_JOINTS)) ? 9'(MAX_JOINTS)
                                                          : 9'(i_joint_count);
    assign inflight = 3'(r_v1) + 3'(r_v2) + 3'(r_v3) + 3'(r_v4) + 3'(r_v5);
    assign is_vtx   = (i_item.kind == KIND_VERTEX);
    assign o_pop    = i_valid && (!is_vtx ||
                      ((LW+1)'(i_out_level) + (LW+1)'(inflight) < (LW+1)'(OUT_DEPTH)));
    assign do_load  = o_pop && !is_vtx;
    assign pos_in[0] = i_item.pos_x;
    assign pos_in[1] = i_item.pos_y;
    assign pos_in[2] = i_item.pos_z;

    // one copy of the table per influence, each with its own read port
    for (genvar b = 0; b < INFL; b++) begin : g_bank
        logic [31:0] r_mem [MAX_JOINTS][ELEMS];
        logic [7:0]  jidx;
        logic [8:0]  widx;
        assign jidx = i_item.joints[8*b +: 8];
        assign widx = 9'(i_item.slot);

        always_ff @(posedge i_clk) begin
            if (do_load) begin
                r_mem[widx[JW-1:0]][i_item.elem] <= i_item.value;
            end
            r_row[b] <= r_mem[jidx[JW-1:0]];
            r_w1[b]  <= i_item.weights[16*b +: 16];
            r_ok1[b] <= (9'(jidx) < limit);
        end
    end

    always_comb begin
        logic signed [31:0] v_el;
        for (int e = 0; e < ELEMS; e++) begin
            for (int b = 0; b < INFL; b++) begin
                if (r_ok1[b]) begin
                    v_el = $signed(r_row[b][e]);
                end else if (e == 0 || e == 5 || e == 10) begin
                    v_el = ONE_Q16;
                end else begin
                    v_el = 32'sd0;
                end
                n_p2[e][b] = $signed({1'b0, r_w1[b]}) * v_el;
            end
        end
    end

    always_comb begin
        logic signed [50:0] v_acc;
        for (int e = 0; e < ELEMS; e++) begin
            v_acc = 51'(r_p2[e][0]) + 51'(r_p2[e][1]) + 51'(r_p2[e][2])
                  + 51'(r_p2[e][3]) + 51'sd16384;
            n_b3[e] = $signed(sat32(72'(v_acc >>> 15)));
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_q4[r][c] = r_b3[r*4+c] * $signed(r_pos3[c]);
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s5[r] = 67'(r_q4[r][0]) + 67'(r_q4[r][1]) + 67'(r_q4[r][2])
                    + (67'(r_t4[r]) <<< 16) + 67'sd32768;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= o_pop && is_vtx;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id1 <= i_identity;
        r_id2 <= r_id1;
        r_id3 <= r_id2;
        r_id4 <= r_id3;
        r_id5 <= r_id4;
        r_pos1 <= pos_in;
        r_pos2 <= r_pos1;
        r_pos3 <= r_pos2;
        r_pos4 <= r_pos3;
        r_pos5 <= r_pos4;
        r_p2 <= n_p2;
        r_b3 <= n_b3;
        r_q4 <= n_q4;
        for (int r = 0; r < 3; r++) begin
            r_t4[r] <= r_b3[r*4+3];
        end
        r_s5 <= n_s5;
    end

    assign o_res_valid = r_v5;
    assign o_res_x = r_id5 ? r_pos5[0] : sat32(72'(r_s5[0] >>> 16));
    assign o_res_y = r_id5 ? r_pos5[1] : sat32(72'(r_s5[1] >>> 16));
    assign o_res_z = r_id5 ? r_pos5[2] : sat32(72'(r_s5[2] >>> 16));

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW+1)'(i_out_level) + (LW+1)'(inflight) <= (LW+1)'(OUT_DEPTH))
        else $error("result queue overbooked");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_valid)
        else $error("pop from empty queue");
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |=> r_v2)
        else $error("pipeline lost an item");
endmodule

### hw/rtl/linear_blend_vertex_skinning_core.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_core
// Four-influence linear blend skinning, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Takes one item per clock while the input queue is not full. A load item
// writes one joint matrix element and gives no result; a vertex item
// gives one result after it leaves the four-entry input queue, through an
// eight-entry result queue. The joint table is held in four copies, one per
// influence, so all four matrices are read in the same cycle. The table is
// not cleared at reset; reading an unwritten entry returns garbage.
module linear_blend_vertex_skinning_core #(
    parameter int MAX_JOINTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [5:0]  i_matrix_slot,
    input  logic [3:0]  i_element_index,
    input  logic signed [31:0] i_element_value,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0] i_joint_indices,
    input  logic [63:0] i_weights,
    output logic        empty,
    input  logic        pop,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import lbvs_pkg::*;

    localparam int OUT_DEPTH = 8;

    t_item       in_item, mid_item;
    logic        mid_valid, mid_pop;
    logic [6:0]  r_joint_count;
    logic        r_identity;
    logic        res_valid;
    logic [31:0] res_x, res_y, res_z;
    logic [95:0] oq_data;
    logic        oq_full;
    logic [$clog2(OUT_DEPTH):0] oq_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= '0;
            r_identity    <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_JOINT_COUNT) begin
                r_joint_count <= i_cfg_data[6:0];
            end else if (i_cfg_index == CFG_IDENTITY) begin
                r_identity <= i_cfg_data[0];
            end
        end
    end

    always_comb begin
        in_item.kind    = i_kind;
        in_item.slot    = i_matrix_slot;
        in_item.elem    = i_element_index;
        in_item.value   = i_element_value;
        in_item.pos_x   = i_pos_x;
        in_item.pos_y   = i_pos_y;
        in_item.pos_z   = i_pos_z;
        in_item.joints  = i_joint_indices;
        in_item.weights = i_weights;
    end

    lbvs_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (in_item),
        .i_pop   (mid_pop),
        .o_valid (mid_valid),
        .o_item  (mid_item)
    );

    lbvs_back #(.MAX_JOINTS(MAX_JOINTS), .OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mid_valid),
        .i_item        (mid_item),
        .o_pop         (mid_pop),
        .i_joint_count (r_joint_count),
        .i_identity    (r_identity),
        .i_out_level   (oq_level),
        .o_res_valid   (res_valid),
        .o_res_x       (res_x),
        .o_res_y       (res_y),
        .o_res_z       (res_z)
    );

    lbvs_fifo #(.WIDTH(96), .DEPTH(OUT_DEPTH)) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_wdata ({res_z, res_y, res_x}),
        .i_pop   (pop),
        .o_rdata (oq_data),
        .o_empty (empty),
        .o_full  (oq_full),
        .o_level (oq_level)
    );

    assign o_out_x = $signed(oq_data[31:0]);
    assign o_out_y = $signed(oq_data[63:32]);
    assign o_out_z = $signed(oq_data[95:64]);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !oq_full || pop)
        else $error("result dropped");
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_joint_count) && $stable(r_identity))
        else $error("config changed without write");
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> (oq_level == '0))
        else $error("empty flag out of step");
endmodule
